[design/pcpd_pkg.sv]
// Shared types and constants of the phase-code pulse decoder.
`default_nettype none

package pcpd_pkg;

  // Sample width of every I and Q field on both channels.
  localparam int SAMPLE_BITS = 16;

  // Four sample lanes travel together: main I, main Q, back I, back Q.
  localparam int N_LANES   = 4;
  localparam int LANE_MI   = 0;
  localparam int LANE_MQ   = 1;
  localparam int LANE_BI   = 2;
  localparam int LANE_BQ   = 3;

  // Configuration register file.
  localparam int BAUD_W     = 5;
  localparam int CODE_W     = 16;
  localparam int CODE_IDX_W = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BAUD_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_SIGNS  = 2'd1;

  localparam logic [BAUD_W-1:0] BAUD_RESET = 5'd1;
  localparam logic [CODE_W-1:0] CODE_RESET = 16'd0;

  typedef logic [N_LANES-1:0][SAMPLE_BITS-1:0] lane_samples_t;

  typedef struct packed {
    logic                          last_sample;
    logic signed [SAMPLE_BITS-1:0] back_q;
    logic signed [SAMPLE_BITS-1:0] back_i;
    logic signed [SAMPLE_BITS-1:0] main_q;
    logic signed [SAMPLE_BITS-1:0] main_i;
  } in_item_t;

  typedef struct packed {
    logic                          seq_end;
    logic signed [SAMPLE_BITS-1:0] dec_back_q;
    logic signed [SAMPLE_BITS-1:0] dec_back_i;
    logic signed [SAMPLE_BITS-1:0] dec_main_q;
    logic signed [SAMPLE_BITS-1:0] dec_main_i;
  } out_item_t;

  // Control broadcast from the sequencer to every window cell.
  typedef struct packed {
    logic shift_en;
    logic clear_sum;
    logic run;
  } cell_ctl_t;

endpackage

`default_nettype wire

[design/phase_code_pulse_decoder.sv]
// Top level of the phase-code pulse decoder: window cell chain, sequencer, divider, output register.
`default_nettype none

// Decodes phase-coded pulses on the main and back receiver channels. Each accepted transaction
// shifts one I/Q sample per channel into a chain of MAX_CODE_LEN window cells. Once the window
// holds at least baud_length samples, the last baud_length samples are correlated with the
// +1/-1 code in code_signs (code element 0 weights the oldest of them), the sums are divided by
// baud_length with truncation toward zero, and the quotients, wrapped to 16 bits, leave as one
// result transaction. A baud_length of 0 acts as 1, values above MAX_CODE_LEN act as
// MAX_CODE_LEN, and a length of 1 passes the newest samples through unchanged. A transaction
// with last_sample set ends the sequence: its result, if any, carries seq_end, and the window
// starts empty again. A transaction that yields no result leaves the block idle. For one that
// yields a result, the partial sum walks one cell per cycle down the chain through the L cells
// of the effective code length, the sums are loaded into the divider, and the divider produces
// one quotient bit per cycle before the result is offered. The input is not ready during that
// time, but the next transaction is taken while a finished result still waits in the output
// register. Configuration writes take effect at once and must only be made while the block is
// idle.
module phase_code_pulse_decoder #(
  parameter int MAX_CODE_LEN = 16
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    in_valid,
  output logic                                   in_ready,
  input  pcpd_pkg::in_item_t                     in_data,
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output pcpd_pkg::out_item_t                    out_data,
  input  wire                                    cfg_we,
  input  wire  [pcpd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire  [pcpd_pkg::CFG_DATA_W-1:0]        cfg_data
);

  // Width of a length or fill count, and of a correlation sum that cannot overflow.
  localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
  localparam int SUM_W = pcpd_pkg::SAMPLE_BITS + LEN_W;
  // Width used to form a code element index from the length and a cell position.
  localparam int JW    = (LEN_W > pcpd_pkg::CODE_IDX_W) ? LEN_W : pcpd_pkg::CODE_IDX_W;

  // Sequencer states.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SUM    = 2'd1;
  localparam logic [1:0] S_DSTART = 2'd2;
  localparam logic [1:0] S_DIV    = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Configuration registers.
  logic [pcpd_pkg::BAUD_W-1:0] baud_r;
  logic [pcpd_pkg::CODE_W-1:0] code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      baud_r <= pcpd_pkg::BAUD_RESET;
      code_r <= pcpd_pkg::CODE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pcpd_pkg::REG_BAUD_LENGTH: baud_r <= cfg_data[pcpd_pkg::BAUD_W-1:0];
        pcpd_pkg::REG_CODE_SIGNS:  code_r <= cfg_data[pcpd_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective code length: zero means one, and the length saturates at the window depth.
  logic [LEN_W-1:0] len_eff;

  always_comb begin
    if (baud_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(baud_r) > MAX_CODE_LEN) begin
      len_eff = LEN_W'(MAX_CODE_LEN);
    end else begin
      len_eff = LEN_W'(baud_r);
    end
  end

  // Fill count of the window, saturating at the depth. The cells themselves are never cleared;
  // after the end of a sequence the count alone says that nothing in them is valid.
  logic [LEN_W-1:0] fill_r;
  logic [LEN_W-1:0] fill_inc;
  logic             accept;
  logic             produce;

  assign accept   = in_valid && in_ready;
  assign fill_inc = (fill_r < LEN_W'(MAX_CODE_LEN)) ? (fill_r + LEN_W'(1)) : fill_r;
  assign produce  = (fill_inc >= len_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= in_data.last_sample ? '0 : fill_inc;
    end
  end

  // Window cell chain. Cell 0 holds the newest sample; the partial sum runs from the far end
  // toward cell 0, gaining one cell's weighted sample per cycle.
  pcpd_pkg::cell_ctl_t     cell_ctl;
  pcpd_pkg::lane_samples_t in_lanes;
  pcpd_pkg::lane_samples_t cell_samp [MAX_CODE_LEN];
  logic [pcpd_pkg::N_LANES-1:0][SUM_W-1:0] cell_psum [MAX_CODE_LEN];

  always_comb begin
    in_lanes                    = '0;
    in_lanes[pcpd_pkg::LANE_MI] = in_data.main_i;
    in_lanes[pcpd_pkg::LANE_MQ] = in_data.main_q;
    in_lanes[pcpd_pkg::LANE_BI] = in_data.back_i;
    in_lanes[pcpd_pkg::LANE_BQ] = in_data.back_q;
  end

  assign cell_ctl.shift_en  = accept;
  assign cell_ctl.clear_sum = accept;
  assign cell_ctl.run       = (state_r == S_SUM);

  for (genvar k = 0; k < MAX_CODE_LEN; k++) begin : g_cell
    logic [JW-1:0] elem;
    logic          in_code;
    logic          neg;

    // Cell k holds the sample that code element len - 1 - k weights. Elements past the code
    // register count as +1, and a length of one ignores the code altogether.
    assign in_code = (LEN_W'(k) < len_eff);
    assign elem    = JW'(len_eff) - JW'(k) - JW'(1);
    assign neg     = in_code && (len_eff != LEN_W'(1))
                     && (elem < JW'(pcpd_pkg::CODE_W))
                     && code_r[elem[pcpd_pkg::CODE_IDX_W-1:0]];

    pcpd_cell #(
      .SUM_W (SUM_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .sample_in  ((k == 0) ? in_lanes : cell_samp[(k == 0) ? 0 : k - 1]),
      .coef_en    (in_code),
      .coef_neg   (neg),
      .psum_in    ((k == MAX_CODE_LEN - 1) ? '0
                   : cell_psum[(k == MAX_CODE_LEN - 1) ? k : k + 1]),
      .sample_out (cell_samp[k]),
      .psum_out   (cell_psum[k])
    );
  end

  // Sequencer: summing in S_SUM, loading the divider in S_DSTART, then the divide itself in S_DIV.
  logic [LEN_W-1:0] sum_cnt_r;
  logic             seq_end_r;
  logic             div_start;
  logic             div_done;
  logic             out_free;
  logic             out_load;
  pcpd_pkg::lane_samples_t quotient;

  assign in_ready  = (state_r == S_IDLE);
  assign div_start = (state_r == S_DSTART);
  assign out_free  = !out_valid || out_ready;
  assign out_load  = (state_r == S_DIV) && div_done && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && produce) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (sum_cnt_r == len_eff - LEN_W'(1)) begin
          state_nxt = S_DSTART;
        end
      end
      S_DSTART: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sum_cnt_r <= '0;
      seq_end_r <= in_data.last_sample;
    end else if (state_r == S_SUM) begin
      sum_cnt_r <= sum_cnt_r + LEN_W'(1);
    end
  end

  pcpd_div #(
    .SUM_W (SUM_W),
    .LEN_W (LEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cell_psum[0]),
    .divisor  (len_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  // Output register: it lets the next input transaction in while a result waits to be taken.
  logic                out_valid_r;
  pcpd_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.dec_main_i <= quotient[pcpd_pkg::LANE_MI];
      out_data_r.dec_main_q <= quotient[pcpd_pkg::LANE_MQ];
      out_data_r.dec_back_i <= quotient[pcpd_pkg::LANE_BI];
      out_data_r.dec_back_q <= quotient[pcpd_pkg::LANE_BQ];
      out_data_r.seq_end    <= seq_end_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[design/pcpd_cell.sv]
// One window cell: holds one sample of each lane and one stage of the partial-sum chain.
`default_nettype none

module pcpd_cell #(
  parameter int SUM_W = 21
) (
  input  wire                                         clk,
  input  pcpd_pkg::cell_ctl_t                         ctl,
  input  pcpd_pkg::lane_samples_t                     sample_in,
  input  wire                                         coef_en,
  input  wire                                         coef_neg,
  input  wire  [pcpd_pkg::N_LANES-1:0][SUM_W-1:0]     psum_in,
  output pcpd_pkg::lane_samples_t                     sample_out,
  output logic [pcpd_pkg::N_LANES-1:0][SUM_W-1:0]     psum_out
);

  localparam int EXT_W = SUM_W - pcpd_pkg::SAMPLE_BITS;

  pcpd_pkg::lane_samples_t                 sample_r;
  logic [pcpd_pkg::N_LANES-1:0][SUM_W-1:0] psum_r;
  logic [pcpd_pkg::N_LANES-1:0][SUM_W-1:0] psum_nxt;

  always_comb begin
    logic [SUM_W-1:0] ext;
    logic [SUM_W-1:0] term;
    for (int l = 0; l < pcpd_pkg::N_LANES; l++) begin
      ext  = {{EXT_W{sample_r[l][pcpd_pkg::SAMPLE_BITS-1]}}, sample_r[l]};
      term = '0;
      if (coef_en) begin
        term = coef_neg ? (~ext + SUM_W'(1)) : ext;
      end
      psum_nxt[l] = psum_in[l] + term;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift_en) begin
      sample_r <= sample_in;
    end
    if (ctl.clear_sum) begin
      psum_r <= '0;
    end else if (ctl.run) begin
      psum_r <= psum_nxt;
    end
  end

  assign sample_out = sample_r;
  assign psum_out   = psum_r;

endmodule

`default_nettype wire

[design/pcpd_div.sv]
// Four-lane restoring divider that turns the signed correlation sums into truncated quotients.
`default_nettype none

module pcpd_div #(
  parameter int SUM_W = 21,
  parameter int LEN_W = 5
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     start,
  input  wire  [pcpd_pkg::N_LANES-1:0][SUM_W-1:0] dividend,
  input  wire  [LEN_W-1:0]                        divisor,
  output logic                                    done,
  output pcpd_pkg::lane_samples_t                 quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);
  localparam int SB    = pcpd_pkg::SAMPLE_BITS;

  logic [CNT_W-1:0]                        cnt_r;
  logic                                    busy_r;
  logic                                    done_r;
  logic [LEN_W-1:0]                        div_r;
  logic [pcpd_pkg::N_LANES-1:0]            neg_r;
  logic [pcpd_pkg::N_LANES-1:0][SUM_W-1:0] quo_r;
  logic [pcpd_pkg::N_LANES-1:0][LEN_W-1:0] rem_r;
  logic [pcpd_pkg::N_LANES-1:0][SUM_W-1:0] quo_nxt;
  logic [pcpd_pkg::N_LANES-1:0][LEN_W-1:0] rem_nxt;

  // One quotient bit per lane and cycle, most significant first.
  always_comb begin
    logic [LEN_W:0] shifted;
    logic [LEN_W:0] diff;
    logic           fits;
    for (int l = 0; l < pcpd_pkg::N_LANES; l++) begin
      shifted    = {rem_r[l], quo_r[l][SUM_W-1]};
      diff       = shifted - {1'b0, div_r};
      fits       = (shifted >= {1'b0, div_r});
      rem_nxt[l] = fits ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
      quo_nxt[l] = {quo_r[l][SUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(SUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
      for (int l = 0; l < pcpd_pkg::N_LANES; l++) begin
        neg_r[l] <= dividend[l][SUM_W-1];
        quo_r[l] <= dividend[l][SUM_W-1] ? (~dividend[l] + SUM_W'(1)) : dividend[l];
        rem_r[l] <= '0;
      end
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // The sign is applied after truncation, which rounds toward zero and wraps to the sample width.
  always_comb begin
    for (int l = 0; l < pcpd_pkg::N_LANES; l++) begin
      quotient[l] = neg_r[l] ? (~quo_r[l][SB-1:0] + SB'(1)) : quo_r[l][SB-1:0];
    end
  end

  assign done = done_r;

endmodule

`default_nettype wire

[design/pcpd_checker.sv]
// Port-level checks of the phase-code pulse decoder and their binding to the top level.
`default_nettype none

module pcpd_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_ready,
  input wire                 out_valid,
  input wire                 out_ready,
  input pcpd_pkg::out_item_t out_data
);

  // Reset empties the output register.
  a_reset_empties_output: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A result only appears after the input side has been held off for the computation.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while the input side was idle");

  // The input side only stops taking transactions after it has accepted one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("input ready dropped without an accepted transaction");

  // A stalled result keeps its contents.
  a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or vanished");

endmodule

bind phase_code_pulse_decoder pcpd_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
